[rtl/core/bsc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, opcodes and constants for the barometric compensation core.
package bsc_pkg;

    // Number of calibration slots.
    localparam int unsigned SlotCount = 12;

    // Slot indexes.
    localparam logic [3:0] SLOT_T1 = 4'd0;
    localparam logic [3:0] SLOT_T2 = 4'd1;
    localparam logic [3:0] SLOT_T3 = 4'd2;
    localparam logic [3:0] SLOT_P1 = 4'd3;
    localparam logic [3:0] SLOT_P2 = 4'd4;
    localparam logic [3:0] SLOT_P3 = 4'd5;
    localparam logic [3:0] SLOT_P4 = 4'd6;
    localparam logic [3:0] SLOT_P5 = 4'd7;
    localparam logic [3:0] SLOT_P6 = 4'd8;
    localparam logic [3:0] SLOT_P7 = 4'd9;
    localparam logic [3:0] SLOT_P8 = 4'd10;
    localparam logic [3:0] SLOT_P9 = 4'd11;

    // Multiplier operand selectors.
    typedef enum logic [4:0] {
        OP_ZERO,
        OP_TA,
        OP_TB,
        OP_TC,
        OP_TD,
        OP_QQ,
        OP_V2A,
        OP_V2B,
        OP_PA,
        OP_PC,
        OP_PD,
        OP_PE,
        OP_DIVA,
        OP_DIVB,
        OP_QA,
        OP_QB,
        OP_QC
    } t_op;

    // Command from controller to datapath.
    typedef struct packed {
        logic start;     // latch inputs
        logic mul;       // run one multiply step
        t_op  op;
        logic div_start; // begin division
        logic div_step;  // one restoring step
        logic finish;    // form outputs
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic zero_div;
    } t_sts;

    localparam logic [31:0] K64000   = 32'd64000;
    localparam logic [31:0] K32768   = 32'd32768;
    localparam logic [31:0] K1048576 = 32'd1048576;
    localparam logic [31:0] K3125    = 32'd3125;
    localparam logic [31:0] KSignBit = 32'h8000_0000;
    localparam logic signed [31:0] TempMin = -32'sd4000;
    localparam logic signed [31:0] TempMax = 32'sd8500;
    localparam logic [31:0] PresMin  = 32'd30000;
    localparam logic [31:0] PresMax  = 32'd110000;

endpackage

[rtl/core/bsc_datapath.sv]
`timescale 1ns / 1ps
// Datapath: calibration table, shared 32x32 multiplier and serial divider.
module bsc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [3:0]         i_cal_index,
    input  logic [15:0]        i_cal_value,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    input  bsc_pkg::t_cmd      i_cmd,
    output bsc_pkg::t_sts      o_sts,
    output logic [14:0]        o_temperature_centi,
    output logic [16:0]        o_pressure_pa,
    output logic               o_divide_guard
);

    logic [15:0] r_cal [bsc_pkg::SlotCount];
    logic [19:0] r_adc_t, r_adc_p;
    logic [31:0] r_fine, r_var1, r_q, r_var2, r_x, r_y, r_p, r_m;
    logic [31:0] r_rem, r_quo, r_dvd, r_dvs;
    logic        r_post;
    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [33:0] trial;
    logic [32:0] rem_sh;
    logic [31:0] tmp, pfin, pres;
    logic signed [31:0] temp_s;

    function automatic logic [31:0] sx(input logic [15:0] v);
        sx = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sar(input logic [31:0] v, input int n);
        sar = 32'($signed(v) >>> n);
    endfunction

    // Calibration table writes, cleared on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bsc_pkg::SlotCount; i++) r_cal[i] <= '0;
        end else if (i_load && (i_cal_index < 4'(bsc_pkg::SlotCount))) begin
            r_cal[i_cal_index] <= i_cal_value;
        end
    end

    assign t1 = {16'd0, r_cal[bsc_pkg::SLOT_T1]};
    assign t2 = sx(r_cal[bsc_pkg::SLOT_T2]);
    assign t3 = sx(r_cal[bsc_pkg::SLOT_T3]);
    assign p1 = {16'd0, r_cal[bsc_pkg::SLOT_P1]};
    assign p2 = sx(r_cal[bsc_pkg::SLOT_P2]);
    assign p3 = sx(r_cal[bsc_pkg::SLOT_P3]);
    assign p4 = sx(r_cal[bsc_pkg::SLOT_P4]);
    assign p5 = sx(r_cal[bsc_pkg::SLOT_P5]);
    assign p6 = sx(r_cal[bsc_pkg::SLOT_P6]);
    assign p7 = sx(r_cal[bsc_pkg::SLOT_P7]);
    assign p8 = sx(r_cal[bsc_pkg::SLOT_P8]);
    assign p9 = sx(r_cal[bsc_pkg::SLOT_P9]);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            bsc_pkg::OP_TA: begin
                mul_a = {15'd0, r_adc_t[19:3]} - (t1 << 1); mul_b = t2;
            end
            bsc_pkg::OP_TB: begin
                mul_a = {16'd0, r_adc_t[19:4]} - t1;
                mul_b = {16'd0, r_adc_t[19:4]} - t1;
            end
            bsc_pkg::OP_TC: begin mul_a = sar(r_m, 12); mul_b = t3; end
            bsc_pkg::OP_TD: begin mul_a = r_fine; mul_b = 32'd5; end
            bsc_pkg::OP_QQ: begin mul_a = r_q; mul_b = r_q; end
            bsc_pkg::OP_V2A: begin mul_a = sar(r_m, 11); mul_b = p6; end
            bsc_pkg::OP_V2B: begin mul_a = r_var1; mul_b = p5; end
            bsc_pkg::OP_PA: begin mul_a = p3; mul_b = sar(r_y, 13); end
            bsc_pkg::OP_PC: begin mul_a = p2; mul_b = r_var1; end
            bsc_pkg::OP_PD: begin
                mul_a = bsc_pkg::K32768 + sar(r_x + sar(r_m, 1), 18); mul_b = p1;
            end
            bsc_pkg::OP_PE: begin
                mul_a = (bsc_pkg::K1048576 - {12'd0, r_adc_p}) - sar(r_var2, 12);
                mul_b = bsc_pkg::K3125;
            end
            bsc_pkg::OP_QA: begin mul_a = {3'd0, r_p[31:3]}; mul_b = {3'd0, r_p[31:3]}; end
            bsc_pkg::OP_QB: begin mul_a = p9; mul_b = r_m >> 13; end
            bsc_pkg::OP_QC: begin mul_a = {2'd0, r_p[31:2]}; mul_b = p8; end
            default: ;
        endcase
    end
    assign prod = 32'(mul_a * mul_b);

    // Divider step and helpers. The shifted remainder keeps 33 bits so that
    // divisors with the top bit set divide correctly.
    assign rem_sh = {r_rem, r_dvd[31]};
    assign trial  = {1'b0, rem_sh} - {2'b0, r_dvs};
    assign tmp    = sar(r_fine * 32'd5 + 32'd128, 8);
    assign temp_s = $signed(tmp);
    assign pfin   = r_p + sar(r_x + sar(r_m, 13) + p7, 4);
    assign pres   = (pfin < bsc_pkg::PresMin) ? bsc_pkg::PresMin :
                    (pfin > bsc_pkg::PresMax) ? bsc_pkg::PresMax : pfin;

    // Sequenced register updates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_adc_t <= i_raw_temperature;
            r_adc_p <= i_raw_pressure;
        end
        if (i_cmd.mul) begin
            r_m <= prod;
            unique case (i_cmd.op)
                bsc_pkg::OP_TB: r_x <= sar(r_m, 11);
                bsc_pkg::OP_TC: begin
                    r_fine <= r_x + sar(prod, 14);
                    r_var1 <= sar(r_x + sar(prod, 14), 1) - bsc_pkg::K64000;
                    r_q    <= sar(sar(r_x + sar(prod, 14), 1)
                              - bsc_pkg::K64000, 2);
                end
                bsc_pkg::OP_QQ: r_y <= prod;
                bsc_pkg::OP_V2A: r_var2 <= prod;
                bsc_pkg::OP_V2B: r_var2 <= sar(r_var2 + (prod << 1), 2) + (p4 << 16);
                bsc_pkg::OP_PC: r_x <= sar(r_m, 3);
                bsc_pkg::OP_PD: r_var1 <= sar(prod, 15);
                bsc_pkg::OP_PE: begin
                    r_post <= prod[31];
                    r_dvd  <= prod[31] ? prod : (prod << 1);
                end
                bsc_pkg::OP_QB: r_x <= sar(prod, 12);
                default: ;
            endcase
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_dvs <= r_var1;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            if (!trial[33]) begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
        if (i_cmd.op == bsc_pkg::OP_DIVB) r_p <= r_post ? (r_quo << 1) : r_quo;
        if (i_cmd.finish) begin
            o_temperature_centi <= (temp_s < bsc_pkg::TempMin) ? 15'(bsc_pkg::TempMin) :
                                   (temp_s > bsc_pkg::TempMax) ? 15'(bsc_pkg::TempMax) :
                                   tmp[14:0];
            o_divide_guard <= (r_var1 == '0);
            o_pressure_pa  <= (r_var1 == '0) ? 17'(bsc_pkg::PresMin) : pres[16:0];
        end
    end

    assign o_sts.zero_div = (r_var1 == '0);

endmodule

[rtl/core/bsc_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences multiply steps, division and the output handshake.
module bsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic          i_out_taken,
    input  bsc_pkg::t_sts i_sts,
    output bsc_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_out_valid
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_POST = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    // Multiply program before the division.
    function automatic bsc_pkg::t_op pre_op(input logic [4:0] k);
        unique case (k)
            5'd0: pre_op = bsc_pkg::OP_TA;
            5'd1: pre_op = bsc_pkg::OP_TB;
            5'd2: pre_op = bsc_pkg::OP_TC;
            5'd3: pre_op = bsc_pkg::OP_QQ;
            5'd4: pre_op = bsc_pkg::OP_V2A;
            5'd5: pre_op = bsc_pkg::OP_V2B;
            5'd6: pre_op = bsc_pkg::OP_QQ;
            5'd7: pre_op = bsc_pkg::OP_PA;
            5'd8: pre_op = bsc_pkg::OP_PC;
            5'd9: pre_op = bsc_pkg::OP_PD;
            5'd10: pre_op = bsc_pkg::OP_PE;
            default: pre_op = bsc_pkg::OP_ZERO;
        endcase
    endfunction

    // Multiply program after the division.
    function automatic bsc_pkg::t_op post_op(input logic [4:0] k);
        unique case (k)
            5'd0: post_op = bsc_pkg::OP_DIVB;
            5'd1: post_op = bsc_pkg::OP_QA;
            5'd2: post_op = bsc_pkg::OP_QB;
            5'd3: post_op = bsc_pkg::OP_QC;
            default: post_op = bsc_pkg::OP_ZERO;
        endcase
    endfunction

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.op = bsc_pkg::OP_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    o_cmd.start = 1'b1;
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.op  = pre_op(r_cnt);
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt == 5'd10) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.zero_div) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        n_cnt   = '0;
                        n_state = S_POST;
                    end
                end
            end
            S_POST: begin
                o_cmd.op  = post_op(r_cnt);
                o_cmd.mul = (r_cnt != 5'd0) && (r_cnt != 5'd4);
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt == 5'd4) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_taken) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // A result appears only after a compensation was started.
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DIV || $past(r_state) == S_POST))
        else $error("result without work");
    // In the post-division phase the counter stays at or below 4.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST) |-> (r_cnt <= 5'd4))
        else $error("post counter overrun");
    // A start only happens from idle.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> (r_state == S_IDLE))
        else $error("start while busy");

endmodule

[rtl/core/barometric_sensor_compensation_core.sv]
`timescale 1ns / 1ps
// Top level of the barometric compensation core.
//
// Channel   Dir  Signals                          Word
// s_axis    in   s_axis_tvalid/tready/tdata/tuser func in tuser; cal and raw fields in tdata
// m_axis    out  m_axis_tvalid/tready/tdata       temperature, pressure, guard
//
// A compensation, after the word is accepted, runs 11 shared multiplier steps,
// 32 steps of the bit-serial divider, one step to take the quotient, 3 more
// multiplies and one step to finish. A zero divisor skips the division and the
// steps after it. Input is stalled while a compensation runs and a result waits.
// Reset is synchronous and clears the calibration table and the controller.
module barometric_sensor_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cal_index[3:0], cal_value[19:4], raw_temperature[39:20],
    // raw_pressure[59:40], zero pad [63:60]
    input  logic [63:0] s_axis_tdata,
    // tuser: func[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: temperature_centi[14:0], pressure_pa[31:15], divide_guard[32],
    // zero pad [39:33]
    output logic [39:0] m_axis_tdata
);

    bsc_pkg::t_cmd cmd;
    bsc_pkg::t_sts sts;
    logic          busy;
    logic          acc;
    logic [14:0]   temp;
    logic [16:0]   pres;
    logic          guard;

    assign s_axis_tready = !busy;
    assign acc = s_axis_tvalid && s_axis_tready;

    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (acc && s_axis_tuser),
        .i_out_taken (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_out_valid (m_axis_tvalid)
    );

    bsc_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (acc && !s_axis_tuser),
        .i_cal_index         (s_axis_tdata[3:0]),
        .i_cal_value         (s_axis_tdata[19:4]),
        .i_raw_temperature   (s_axis_tdata[39:20]),
        .i_raw_pressure      (s_axis_tdata[59:40]),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_temperature_centi (temp),
        .o_pressure_pa       (pres),
        .o_divide_guard      (guard)
    );

    assign m_axis_tdata = {7'd0, guard, pres, temp};

endmodule
